### hdl/windowed_group_count_max_top_defines.svh
// Assertion macros shared by the checker.
`ifndef WINDOWED_GROUP_COUNT_MAX_TOP_DEFINES_SVH
`define WINDOWED_GROUP_COUNT_MAX_TOP_DEFINES_SVH
`define WGC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
`define WGC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`endif

### hdl/wgcm_pkg.sv
`default_nettype none
package wgcm_pkg;
  localparam int unsigned TableEntries = 64;
  localparam int unsigned SpanW = 48;
  localparam int unsigned KeyW = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned DestW = 7;
  localparam int unsigned RankW = 6;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegSpan = 1'b0;
  localparam logic [CfgIdxW-1:0] RegDest = 1'b1;
  localparam logic [SpanW-1:0] SpanReset = 48'd10000;
  localparam logic [DestW-1:0] DestReset = 7'd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_MOD, ST_SCAN, ST_WAIT, ST_UPD,
    ST_FADDR, ST_FRD, ST_FOUT
  } state_t;

  typedef struct packed {
    logic [SpanW-1:0]  window;
    logic [KeyW-1:0]   campaign;
    logic [CountW-1:0] count;
    logic [SpanW-1:0]  latest;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [SpanW-1:0] dividend;
    logic [SpanW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SpanW-1:0] quot;
    logic [SpanW-1:0] rem;
  } div_rsp_t;
endpackage
`default_nettype wire

### hdl/wgcm_div.sv
`default_nettype none
module wgcm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  wgcm_pkg::div_req_t  req,
  output wgcm_pkg::div_rsp_t  rsp
);
  import wgcm_pkg::*;

  logic [SpanW-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [SpanW:0] trial;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {r_r, q_r[SpanW-1]} - {1'b0, d_r};
    if (req.start) begin
      q_nxt = req.dividend;
      r_nxt = '0;
      d_nxt = req.divisor;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[SpanW]) begin
        r_nxt = trial[SpanW-1:0];
        q_nxt = {q_r[SpanW-2:0], 1'b1};
      end else begin
        r_nxt = {r_r[SpanW-2:0], q_r[SpanW-1]};
        q_nxt = {q_r[SpanW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(SpanW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp = '{done: done_r, quot: q_r, rem: r_r};
endmodule
`default_nettype wire

### hdl/wgcm_table.sv
`default_nettype none
module wgcm_table #(
  parameter int unsigned ENTRIES = wgcm_pkg::TableEntries
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(ENTRIES)-1:0] waddr,
  input  wgcm_pkg::entry_t           wdata,
  input  logic [$clog2(ENTRIES)-1:0] raddr,
  output wgcm_pkg::entry_t           rdata
);
  import wgcm_pkg::*;

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hdl/windowed_group_count_max_top.sv
// Tumbling-window group-by with count and maximum.
// Input channel in_*: one event per beat (campaign key, event time, batch end).
// Output channel out_*: one aggregate per beat, produced only by a flush.
// Configuration: cfg_we writes cfg_data to register cfg_idx (0 span, 1 ranks).
// Write only while the block is idle; the block itself does not enforce this.
// Occupied slots always sit below a fill count, so a new key takes the slot at
// the fill count and only the occupied slots are searched.
// Each event runs through a 48-step restoring divider for its window and then
// compares the occupied slots one at a time, stopping at a hit; the next event
// is taken only after the table has been updated.
// A batch-end event then walks the occupied slots, and a second divider pass
// gives each rank before its aggregate is loaded.
// After the last aggregate has been loaded, the walk passes through ST_FADDR
// back to ST_IDLE before a new event is taken.
// Reset clears the fill count and overflow flag; the table needs no clearing.
// While the receiver stalls, the result register holds its beat and the walk
// waits; no new event is taken until the flush has finished.
`default_nettype none
module windowed_group_count_max_top #(
  parameter int unsigned TABLE_ENTRIES = wgcm_pkg::TableEntries
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [wgcm_pkg::KeyW-1:0]    in_campaign_key,
  input  logic [wgcm_pkg::SpanW-1:0]   in_event_time,
  input  logic                         in_batch_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [wgcm_pkg::SpanW-1:0]   out_win_num,
  output logic [wgcm_pkg::KeyW-1:0]    out_campaign_out,
  output logic [wgcm_pkg::CountW-1:0]  out_evt_total,
  output logic [wgcm_pkg::SpanW-1:0]   out_latest_time,
  output logic [wgcm_pkg::RankW-1:0]   out_dest_rank,
  output logic                         out_overflowed,
  output logic                         out_last,
  input  logic                         cfg_we,
  input  logic [wgcm_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [wgcm_pkg::SpanW-1:0]   cfg_data
);
  import wgcm_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = AW + 1;

  state_t state_r, state_nxt;
  logic [SpanW-1:0] span_r;
  logic [DestW-1:0] dest_r;
  logic [CW-1:0] fill_r, fill_nxt;
  logic ovf_r, ovf_nxt;
  logic [KeyW-1:0] key_r;
  logic [SpanW-1:0] time_r, win_r, win_nxt;
  logic end_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic hit_r, hit_nxt;
  entry_t flush_r, flush_nxt;
  logic ov_r, ov_nxt;
  logic [SpanW-1:0] o_win_r, o_lat_r;
  logic [KeyW-1:0] o_key_r;
  logic [CountW-1:0] o_cnt_r;
  logic [RankW-1:0] o_rank_r;
  logic o_ovf_r, o_last_r;
  logic o_load;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t mem_wdata, mem_rdata;
  logic [DestW-1:0] ranks;

  wgcm_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  wgcm_table #(.ENTRIES(TABLE_ENTRIES)) u_table (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  assign ranks = (dest_r == '0) ? DestW'(1) :
                 (dest_r > DestW'(64)) ? DestW'(64) : dest_r;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) state_nxt = (fill_r == '0) ? ST_UPD : ST_SCAN;
      end
      ST_SCAN: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (hit_nxt || idx_r == fill_r) state_nxt = ST_UPD;
        else state_nxt = ST_SCAN;
      end
      ST_UPD:  state_nxt = end_r ? ST_FADDR : ST_IDLE;
      ST_FADDR: begin
        if (idx_r == fill_r) state_nxt = ST_IDLE;
        else state_nxt = ST_FRD;
      end
      ST_FRD:  state_nxt = ST_MOD;
      ST_MOD:  if (div_rsp.done) state_nxt = ST_FOUT;
      ST_FOUT: if (!out_valid || out_ready) state_nxt = ST_FADDR;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    div_req = '{start: 1'b0, dividend: '0, divisor: '0};
    mem_we = 1'b0;
    mem_waddr = slot_r;
    mem_wdata = mem_rdata;
    mem_raddr = idx_r[AW-1:0];
    win_nxt = win_r;
    idx_nxt = idx_r;
    slot_nxt = slot_r;
    hit_nxt = hit_r;
    fill_nxt = fill_r;
    ovf_nxt = ovf_r;
    flush_nxt = flush_r;
    ov_nxt = ov_r;
    o_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        div_req.start = in_valid;
        div_req.dividend = in_event_time;
        div_req.divisor = (span_r == '0) ? SpanW'(1) : span_r;
        idx_nxt = '0;
        hit_nxt = 1'b0;
      end
      ST_DIV: if (div_rsp.done) win_nxt = div_rsp.quot;
      ST_SCAN: begin
        slot_nxt = idx_r[AW-1:0];
        idx_nxt = idx_r + CW'(1);
      end
      ST_WAIT: begin
        mem_raddr = slot_r;
        if (mem_rdata.window == win_r && mem_rdata.campaign == key_r) hit_nxt = 1'b1;
      end
      ST_UPD: begin
        if (hit_r) begin
          mem_we = 1'b1;
          mem_waddr = slot_r;
          mem_wdata = mem_rdata;
          if (mem_rdata.count != '1) mem_wdata.count = mem_rdata.count + CountW'(1);
          if (mem_rdata.latest < time_r) mem_wdata.latest = time_r;
        end else if (fill_r != CW'(TABLE_ENTRIES)) begin
          mem_we = 1'b1;
          mem_waddr = fill_r[AW-1:0];
          mem_wdata = '{window: win_r, campaign: key_r, count: CountW'(1),
                        latest: time_r};
          fill_nxt = fill_r + CW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        idx_nxt = '0;
      end
      ST_FADDR: begin
        if (idx_r == fill_r) begin
          fill_nxt = '0;
          ovf_nxt = 1'b0;
        end
      end
      ST_FRD: begin
        slot_nxt = idx_r[AW-1:0];
        flush_nxt = mem_rdata;
        ov_nxt = ovf_r;
        idx_nxt = idx_r + CW'(1);
        div_req.start = 1'b1;
        div_req.dividend = mem_rdata.window;
        div_req.divisor = SpanW'(ranks);
      end
      ST_FOUT: if (!out_valid || out_ready) o_load = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    idx_r <= idx_nxt;
    slot_r <= slot_nxt;
    hit_r <= hit_nxt;
    flush_r <= flush_nxt;
    ov_r <= ov_nxt;
    if (in_valid && in_ready) begin
      key_r <= in_campaign_key;
      time_r <= in_event_time;
      end_r <= in_batch_end;
    end
    if (o_load) begin
      o_win_r <= flush_r.window;
      o_key_r <= flush_r.campaign;
      o_cnt_r <= flush_r.count;
      o_lat_r <= flush_r.latest;
      o_rank_r <= div_rsp.rem[RankW-1:0];
      o_ovf_r <= ov_r;
      o_last_r <= (idx_r == fill_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      span_r <= SpanReset;
      dest_r <= DestReset;
      fill_r <= '0;
      ovf_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      ovf_r <= ovf_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          RegSpan: span_r <= cfg_data;
          RegDest: dest_r <= cfg_data[DestW-1:0];
          default: ;
        endcase
      end
      if (o_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign out_win_num = o_win_r;
  assign out_campaign_out = o_key_r;
  assign out_evt_total = o_cnt_r;
  assign out_latest_time = o_lat_r;
  assign out_dest_rank = o_rank_r;
  assign out_overflowed = o_ovf_r;
  assign out_last = o_last_r;
endmodule
`default_nettype wire

### hdl/wgcm_checker.sv
`default_nettype none
`include "windowed_group_count_max_top_defines.svh"
module wgcm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [wgcm_pkg::CountW-1:0] out_evt_total,
  input logic                        out_last
);
  import wgcm_pkg::*;

  `WGC_ASSERT_IMP(a_count_nonzero, clk, rst_n, out_valid, out_evt_total != '0)
  `WGC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `WGC_ASSERT_IMP(a_no_accept_while_out, clk, rst_n, out_valid && !out_last, !in_ready)
  `WGC_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind windowed_group_count_max_top wgcm_checker u_wgcm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_evt_total(out_evt_total), .out_last(out_last)
);
`default_nettype wire

### dv/tb_windowed_group_count_max_top.sv
`default_nettype none
module tb_windowed_group_count_max_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wgcm_pkg::*;

  localparam int unsigned SLOTS = TableEntries;
  localparam int unsigned SETTLE_CYCLES = 400;
  localparam longint unsigned CYCLE_LIMIT = 10_000_000;
  localparam int unsigned ITEM_GOAL = 370;
  localparam logic [CountW-1:0] COUNT_CEIL = '1;
  localparam logic [SpanW-1:0] SPAN_MAX = '1;

  typedef struct packed {
    logic [SpanW-1:0]  window;
    logic [KeyW-1:0]   campaign;
    logic [CountW-1:0] count;
    logic [SpanW-1:0]  latest;
    logic [RankW-1:0]  rank;
    logic              ovf;
    logic              last;
  } aggregate_t;

  typedef struct {
    logic [KeyW-1:0]  key;
    logic [SpanW-1:0] tstamp;
    logic             end_flag;
    logic             typed;
    aggregate_t       want;
  } event_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [KeyW-1:0]    in_campaign_key;
  logic [SpanW-1:0]   in_event_time;
  logic               in_batch_end;
  logic               out_valid;
  logic               out_ready;
  logic [SpanW-1:0]   out_win_num;
  logic [KeyW-1:0]    out_campaign_out;
  logic [CountW-1:0]  out_evt_total;
  logic [SpanW-1:0]   out_latest_time;
  logic [RankW-1:0]   out_dest_rank;
  logic               out_overflowed;
  logic               out_last;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [SpanW-1:0]   cfg_data;

  logic       row_typed;
  aggregate_t row_want;
  logic       no_idle;

  logic [SpanW-1:0]  span_reg;
  logic [DestW-1:0]  dest_reg;
  logic              slot_used [SLOTS];
  logic [SpanW-1:0]  slot_win [SLOTS];
  logic [KeyW-1:0]   slot_key [SLOTS];
  logic [CountW-1:0] slot_count [SLOTS];
  logic [SpanW-1:0]  slot_latest [SLOTS];
  logic              table_overflow;

  aggregate_t pending_aggregates[$];
  int unsigned errors;
  int unsigned events_sent;
  int unsigned aggregates_seen;
  int unsigned flushes;
  int unsigned overflow_batches;
  longint unsigned cycles;

  windowed_group_count_max_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_campaign_key(in_campaign_key), .in_event_time(in_event_time),
    .in_batch_end(in_batch_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_win_num(out_win_num), .out_campaign_out(out_campaign_out),
    .out_evt_total(out_evt_total), .out_latest_time(out_latest_time),
    .out_dest_rank(out_dest_rank), .out_overflowed(out_overflowed),
    .out_last(out_last),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles.", cycles);
      $display("FAIL windowed_group_count_max_top");
      $finish;
    end
  end

  // Folds one event into the predicted window table.
  function automatic void absorb_event(logic [KeyW-1:0] key, logic [SpanW-1:0] t);
    logic [SpanW-1:0] divisor;
    logic [SpanW-1:0] win;
    int hole;
    divisor = (span_reg == '0) ? SpanW'(1) : span_reg;
    win = t / divisor;
    hole = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i]) begin
        if (slot_win[i] == win && slot_key[i] == key) begin
          if (slot_count[i] != COUNT_CEIL) slot_count[i] = slot_count[i] + 1'b1;
          if (slot_latest[i] < t) slot_latest[i] = t;
          return;
        end
      end else if (hole < 0) begin
        hole = i;
      end
    end
    if (hole < 0) begin
      table_overflow = 1'b1;
    end else begin
      slot_used[hole] = 1'b1;
      slot_win[hole] = win;
      slot_key[hole] = key;
      slot_count[hole] = CountW'(1);
      slot_latest[hole] = t;
    end
  endfunction

  // Empties the predicted table into a list of aggregates in slot order.
  function automatic void drain_table(ref aggregate_t res[$]);
    logic [SpanW-1:0] ranks;
    aggregate_t a;
    ranks = (dest_reg == '0) ? SpanW'(1) : (dest_reg > 7'd64) ? SpanW'(64) : SpanW'(dest_reg);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i]) begin
        a.window = slot_win[i];
        a.campaign = slot_key[i];
        a.count = slot_count[i];
        a.latest = slot_latest[i];
        a.rank = RankW'(slot_win[i] % ranks);
        a.ovf = table_overflow;
        a.last = 1'b0;
        res = {res, a};
      end
      slot_used[i] = 1'b0;
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    table_overflow = 1'b0;
  endfunction

  always @(posedge clk) begin : event_monitor
    aggregate_t flushed[$];
    if (rst_n && in_valid && in_ready) begin
      absorb_event(in_campaign_key, in_event_time);
      if (in_batch_end) begin
        flushes++;
        flushed = {};
        drain_table(flushed);
        if (row_typed) pending_aggregates = {pending_aggregates, row_want};
        else pending_aggregates = {pending_aggregates, flushed};
      end
    end
  end

  function automatic void compare_field(string name, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : aggregate_monitor
    aggregate_t want;
    if (rst_n && out_valid && out_ready) begin
      aggregates_seen++;
      if (pending_aggregates.size() == 0) begin
        errors++;
        $display("%0t: unexpected aggregate beat, expected none, got window 0x%0h key 0x%0h",
                 $time, out_win_num, out_campaign_out);
      end else begin
        want = pending_aggregates[0];
        pending_aggregates.delete(0);
        compare_field("window number", want.window, out_win_num);
        compare_field("campaign_out", want.campaign, out_campaign_out);
        compare_field("count", want.count, out_evt_total);
        compare_field("latest_time", want.latest, out_latest_time);
        compare_field("dest_rank", want.rank, out_dest_rank);
        compare_field("overflowed", want.ovf, out_overflowed);
        compare_field("last", want.last, out_last);
      end
    end
  end

  initial begin : sink_pacing
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      @(negedge clk);
      repeat (stall) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_event(event_row_t row);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_campaign_key <= row.key;
    in_event_time <= row.tstamp;
    in_batch_end <= row.end_flag;
    row_typed <= row.typed;
    row_want <= row.want;
    do @(posedge clk); while (!in_ready);
    events_sent++;
  endtask

  task automatic plain_event(logic [KeyW-1:0] key, logic [SpanW-1:0] t, logic e);
    event_row_t row;
    row.key = key;
    row.tstamp = t;
    row.end_flag = e;
    row.typed = 1'b0;
    row.want = '0;
    send_event(row);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_aggregates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [SpanW-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    if (idx == RegSpan) span_reg = value;
    else dest_reg = value[DestW-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_batch(int kind);
    logic [KeyW-1:0]  key_base;
    logic [SpanW-1:0] t_base;
    logic [SpanW-1:0] step;
    logic [KeyW-1:0]  key;
    logic [SpanW-1:0] t;
    int len;
    key_base = $urandom;
    t_base = {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
    step = (span_reg > 1) ? (span_reg >> 1) : SpanW'(1);
    len = (kind == 1) ? 70 : (kind == 2) ? $urandom_range(1, 6) : $urandom_range(1, 12);
    if (kind == 1) overflow_batches++;
    for (int j = 0; j < len; j++) begin
      if (kind == 1) begin
        key = key_base + KeyW'(j);
        t = t_base;
      end else if (kind == 2 || $urandom_range(0, 5) == 0) begin
        key = $urandom;
        t = {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
      end else begin
        key = key_base + KeyW'($urandom_range(0, 3));
        t = t_base + step * SpanW'($urandom_range(0, 4)) + SpanW'($urandom_range(0, 1));
      end
      if (kind == 1 && j >= 66) key = key_base + KeyW'(j - 66);
      plain_event(key, t, j == len - 1);
    end
  endtask

  event_row_t reset_rows[] = '{
    '{32'h0, 48'h0, 1'b1, 1'b1,
      '{48'd0, 32'h0, 16'd1, 48'h0, 6'd0, 1'b0, 1'b1}},
    '{32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1,
      '{48'd28147497671, 32'hFFFF_FFFF, 16'd1, 48'hFFFF_FFFF_FFFF, 6'd0, 1'b0, 1'b1}},
    '{32'd5, 48'd25000, 1'b0, 1'b0, '0},
    '{32'd5, 48'd29999, 1'b0, 1'b0, '0},
    '{32'd5, 48'd21000, 1'b0, 1'b0, '0},
    '{32'd6, 48'd25000, 1'b0, 1'b0, '0},
    '{32'd5, 48'd30000, 1'b0, 1'b0, '0},
    '{32'hA5A5_5A5A, 48'h5555_AAAA_5555, 1'b0, 1'b0, '0},
    '{32'd7, 48'd1, 1'b1, 1'b1 ^ 1'b1, '0}
  };

  logic [SpanW-1:0] phase_span[7] = '{48'd10000, 48'd1, 48'd0, SPAN_MAX, 48'd3, 48'd1000, 48'd7};
  logic [SpanW-1:0] phase_dest[7] = '{48'd1, 48'd64, 48'd0, 48'd127, 48'd7, 48'd100, 48'd1};

  initial begin
    int phase_items;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_campaign_key = '0;
    in_event_time = '0;
    in_batch_end = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = RegSpan;
    cfg_data = '0;
    row_typed = 1'b0;
    row_want = '0;
    no_idle = 1'b0;
    cycles = 0;
    errors = 0;
    events_sent = 0;
    aggregates_seen = 0;
    flushes = 0;
    overflow_batches = 0;
    span_reg = SpanReset;
    dest_reg = DestReset;
    table_overflow = 1'b0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (reset_rows[i]) send_event(reset_rows[i]);
    wait_idle();
    write_reg(RegSpan, 48'd0);
    write_reg(RegDest, 48'd127);
    plain_event(32'd9, 48'd4, 1'b0);
    plain_event(32'd9, 48'd4, 1'b0);
    plain_event(32'd9, 48'd70, 1'b1);
    wait_idle();

    for (int p = 0; events_sent < ITEM_GOAL || p < 7; p++) begin
      write_reg(RegSpan, phase_span[p % 7]);
      write_reg(RegDest, phase_dest[p % 7]);
      phase_items = events_sent;
      if (p == 1 || p == 3) random_batch(1);
      while (events_sent - phase_items < 40) begin
        no_idle = ($urandom_range(0, 3) == 0);
        random_batch(($urandom_range(0, 4) == 0) ? 2 : 0);
      end
      no_idle = 1'b0;
      wait_idle();
    end

    $display("Sent %0d events in %0d batches, %0d with a full table; checked %0d aggregates.",
             events_sent, flushes, overflow_batches, aggregates_seen);
    if (errors == 0) begin
      $display("PASS windowed_group_count_max_top");
    end else begin
      $display("FAIL windowed_group_count_max_top");
    end
    $finish;
  end
endmodule
`default_nettype wire
